// ===== design/xie_pkg.sv =====
// Shared types, constants and helpers for the x86-64 instruction byte encoder.
`timescale 1ns / 1ps
package xie_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int CAP_BITS    = 17;
	localparam int QDEPTH      = 4;
	localparam int QPTR_BITS   = $clog2(QDEPTH);

	localparam logic [1:0] MOD_MEM8  = 2'd1;
	localparam logic [1:0] MOD_MEM32 = 2'd2;
	localparam logic [1:0] MOD_REG   = 2'd3;

	localparam logic [6:0] OP_REWIND = 7'd71;

	// One decoded instruction: prefix/opcode bytes, ModRM, SIB, disp, imm.
	typedef struct packed {
		logic        rewind;
		logic [1:0]  np;
		logic [2:0][7:0] pre;
		logic        mr_en;
		logic [7:0]  mr;
		logic        sib;
		logic [2:0]  dl;
		logic [2:0]  il;
		logic [31:0] disp;
		logic [31:0] imm;
	} xie_desc_t;

	function automatic logic fits8(input logic [31:0] v);
		return (v <= 32'h7f) || (v >= 32'hffffff80);
	endfunction

	function automatic logic [7:0] rex(input logic [3:0] r, input logic [3:0] b);
		return 8'h48 | {5'd0, r[3], 1'b0, b[3]};
	endfunction

endpackage

// ===== design/xie_front.sv =====
// Front end: decodes one request into a byte descriptor.
`timescale 1ns / 1ps
module xie_front import xie_pkg::*; (
	input  logic [6:0]  opcode,
	input  logic [3:0]  reg_a,
	input  logic [3:0]  reg_b,
	input  logic [3:0]  cond_code,
	input  logic [31:0] displacement,
	input  logic [31:0] immediate,
	output logic        push,
	output xie_desc_t   desc
);

	logic [1:0] np;
	logic [2:0][7:0] pre;
	logic       mr_en, use_mem, f8i;
	logic [1:0] md;
	logic [2:0] mreg;
	logic [2:0] mrm;
	logic [2:0] dl, il;
	logic [2:0] sext;

	always_comb begin
		push    = 1'b1;
		np      = 2'd0;
		pre     = '0;
		mr_en   = 1'b0;
		use_mem = 1'b0;
		md      = MOD_REG;
		mreg    = reg_b[2:0];
		mrm     = reg_a[2:0];
		dl      = 3'd0;
		il      = 3'd0;
		f8i     = fits8(immediate);
		sext    = 3'd0;
		desc    = '0;
		case (opcode)
			7'd0, 7'd33, 7'd36: begin
				pre[0] = rex(reg_b, reg_a);
				pre[1] = (opcode == 7'd0) ? 8'h89 : (opcode == 7'd33) ? 8'h31 : 8'h39;
				np = 2'd2; mr_en = 1'b1;
			end
			7'd1, 7'd18, 7'd21, 7'd24, 7'd32, 7'd35, 7'd37: begin
				case (opcode)
					7'd1:    pre[0] = 8'h89;
					7'd18:   pre[0] = 8'h01;
					7'd21:   pre[0] = 8'h21;
					7'd24:   pre[0] = 8'h29;
					7'd32:   pre[0] = 8'h31;
					7'd35:   pre[0] = 8'h09;
					default: pre[0] = 8'h39;
				endcase
				np = 2'd1; mr_en = 1'b1;
			end
			7'd2: begin
				pre[0] = 8'hb8 | {5'd0, reg_a[2:0]}; np = 2'd1; il = 3'd4;
			end
			7'd3: begin
				pre[0] = rex(4'd0, reg_a); pre[1] = 8'hc7; np = 2'd2;
				mr_en = 1'b1; mreg = 3'd0; il = 3'd4;
			end
			7'd4, 7'd6, 7'd13: begin
				pre[0] = rex(reg_b, reg_a);
				pre[1] = (opcode == 7'd4) ? 8'h89 : (opcode == 7'd6) ? 8'h8b : 8'h63;
				np = 2'd2; use_mem = 1'b1;
			end
			7'd5: begin
				pre[0] = 8'hc7; np = 2'd1; use_mem = 1'b1; mreg = 3'd0; il = 3'd4;
			end
			7'd7:  begin pre[0] = 8'hc3; np = 2'd1; end
			7'd8, 7'd9, 7'd66, 7'd67, 7'd68: begin
				case (opcode)
					7'd8:    pre[0] = 8'h8b;
					7'd9:    pre[0] = 8'h89;
					7'd66:   pre[0] = 8'h3b;
					7'd67:   pre[0] = 8'h39;
					default: pre[0] = 8'h01;
				endcase
				np = 2'd1; use_mem = 1'b1;
			end
			7'd10, 7'd11, 7'd14, 7'd15: begin
				pre[0] = 8'h0f;
				case (opcode)
					7'd10:   pre[1] = 8'hbe;
					7'd11:   pre[1] = 8'hbf;
					7'd14:   pre[1] = 8'hb6;
					default: pre[1] = 8'hb7;
				endcase
				np = 2'd2; mr_en = 1'b1; mreg = reg_a[2:0]; mrm = reg_b[2:0];
			end
			7'd12: begin
				pre[0] = rex(reg_a, 4'd0); pre[1] = 8'h63; np = 2'd2;
				mr_en = 1'b1; mreg = reg_a[2:0]; mrm = reg_b[2:0];
			end
			7'd16, 7'd17, 7'd22, 7'd23: begin
				if (immediate == 32'd0) begin
					push = 1'b0;
				end else begin
					if (opcode == 7'd16 || opcode == 7'd22) begin
						pre[0] = rex(4'd0, reg_a); np = 2'd1;
					end
					mreg = (opcode == 7'd16 || opcode == 7'd17) ? 3'd0 : 3'd5;
					if (f8i) begin
						pre[np] = 8'h83; mr_en = 1'b1; il = 3'd1;
					end else if (reg_a == 4'd0) begin
						pre[np] = (opcode == 7'd16 || opcode == 7'd17) ? 8'h05 : 8'h2d;
						il = 3'd4;
					end else begin
						pre[np] = 8'h81; mr_en = 1'b1; il = 3'd4;
					end
					np = np + 2'd1;
				end
			end
			7'd19: begin
				if (immediate[7:0] == 8'hff) begin
					push = 1'b0;
				end else begin
					np = 2'd1; il = 3'd1;
					if (reg_a == 4'd0) begin
						pre[0] = 8'h24;
					end else begin
						pre[0] = 8'h80; mr_en = 1'b1; mreg = 3'd4;
					end
				end
			end
			7'd20, 7'd31, 7'd34, 7'd38: begin
				if ((opcode == 7'd20 && immediate == 32'hffffffff) ||
				    ((opcode == 7'd31 || opcode == 7'd34) && immediate == 32'd0)) begin
					push = 1'b0;
				end else begin
					np = 2'd1; il = 3'd4;
					case (opcode)
						7'd20:   mreg = 3'd4;
						7'd31:   mreg = 3'd6;
						7'd34:   mreg = 3'd1;
						default: mreg = 3'd7;
					endcase
					if (reg_a == 4'd0) begin
						case (opcode)
							7'd20:   pre[0] = 8'h25;
							7'd31:   pre[0] = 8'h35;
							7'd34:   pre[0] = 8'h0d;
							default: pre[0] = 8'h3d;
						endcase
					end else begin
						pre[0] = 8'h81; mr_en = 1'b1;
					end
				end
			end
			7'd25, 7'd27, 7'd29: begin
				mreg = (opcode == 7'd25) ? 3'd4 : (opcode == 7'd27) ? 3'd7 : 3'd5;
				if (immediate[7:0] == 8'd0) begin
					push = 1'b0;
				end else begin
					np = 2'd1; mr_en = 1'b1;
					if (immediate[7:0] == 8'd1) begin
						pre[0] = 8'hd1;
					end else begin
						pre[0] = 8'hc1; il = 3'd1;
					end
				end
			end
			7'd26, 7'd28, 7'd30, 7'd40, 7'd41: begin
				pre[0] = (opcode == 7'd40 || opcode == 7'd41) ? 8'hf7 : 8'hd3;
				np = 2'd1; mr_en = 1'b1;
				case (opcode)
					7'd26, 7'd40: mreg = 3'd4;
					7'd28:        mreg = 3'd7;
					default:      mreg = 3'd5;
				endcase
			end
			7'd39: begin pre[0] = 8'hff; np = 2'd1; use_mem = 1'b1; mreg = 3'd2; end
			7'd42: begin pre[0] = 8'h50 | {5'd0, reg_a[2:0]}; np = 2'd1; end
			7'd43: begin pre[0] = 8'h58 | {5'd0, reg_a[2:0]}; np = 2'd1; end
			7'd44: begin pre[0] = 8'h90; np = 2'd1; end
			7'd45: begin
				pre[0] = 8'h0f; pre[1] = 8'h90 | {4'd0, cond_code}; np = 2'd2;
				mr_en = 1'b1; mreg = 3'd0;
			end
			7'd46: begin
				pre[0] = 8'h0f; pre[1] = 8'h40 | {4'd0, cond_code}; np = 2'd2;
				mr_en = 1'b1; mreg = reg_a[2:0]; mrm = reg_b[2:0];
			end
			7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55: begin
				pre[0] = 8'hf3; pre[1] = 8'h0f; np = 2'd3;
				case (opcode)
					7'd47:   pre[2] = 8'h10;
					7'd48:   pre[2] = 8'h11;
					7'd49:   pre[2] = 8'h58;
					7'd50:   pre[2] = 8'h5c;
					7'd51:   pre[2] = 8'h59;
					7'd52:   pre[2] = 8'h5e;
					7'd53:   pre[2] = 8'h51;
					7'd54:   pre[2] = 8'h2c;
					default: pre[2] = 8'h2a;
				endcase
				mr_en = 1'b1; md = MOD_MEM32; dl = 3'd4;
			end
			7'd56, 7'd57: begin
				pre[0] = 8'h66; pre[1] = 8'h0f;
				pre[2] = (opcode == 7'd56) ? 8'h7e : 8'h6e;
				np = 2'd3; mr_en = 1'b1;
			end
			7'd58, 7'd59, 7'd60, 7'd61, 7'd62: begin
				case (opcode)
					7'd58:   sext = 3'd0;
					7'd59:   sext = 3'd5;
					7'd60:   sext = 3'd4;
					7'd61:   sext = 3'd1;
					default: sext = 3'd6;
				endcase
				pre[0] = f8i ? 8'h83 : 8'h81; np = 2'd1;
				use_mem = 1'b1; mreg = sext; il = f8i ? 3'd1 : 3'd4;
			end
			7'd63, 7'd64, 7'd65: begin
				pre[0] = 8'hc1; np = 2'd1; use_mem = 1'b1; il = 3'd1;
				mreg = (opcode == 7'd63) ? 3'd4 : (opcode == 7'd64) ? 3'd5 : 3'd7;
			end
			7'd69, 7'd70: begin
				pre[0] = 8'hf7; np = 2'd1; use_mem = 1'b1;
				mreg = (opcode == 7'd69) ? 3'd4 : 3'd5;
			end
			OP_REWIND: begin
				desc.rewind = 1'b1;
			end
			default: push = 1'b0;
		endcase
		if (use_mem) begin
			mr_en = 1'b1;
			md    = fits8(displacement) ? MOD_MEM8 : MOD_MEM32;
			dl    = fits8(displacement) ? 3'd1 : 3'd4;
		end
		desc.np    = np;
		desc.pre   = pre;
		desc.mr_en = mr_en;
		desc.mr    = {md, mreg, mrm};
		desc.sib   = mr_en && (md != MOD_REG) && (mrm == 3'd4);
		desc.dl    = dl;
		desc.il    = il;
		desc.disp  = displacement;
		desc.imm   = immediate;
	end

endmodule

// ===== design/xie_queue.sv =====
// Short descriptor queue between decode and byte emission.
`timescale 1ns / 1ps
module xie_queue import xie_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  xie_desc_t wdata,
	output logic      full,
	input  logic      rd,
	output logic      empty,
	output xie_desc_t rdata
);

	xie_desc_t mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wp_q, rp_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_BITS+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 1'b1;
			if (rd && !empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(wr && !full) - (QPTR_BITS+1)'(rd && !empty);
		end
	end

endmodule

// ===== design/xie_back.sv =====
// Back end: walks a descriptor byte by byte and tracks the buffer offset.
`timescale 1ns / 1ps
module xie_back import xie_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CAP_BITS-1:0]    cfg_wdata,
	input  logic                   q_empty,
	input  xie_desc_t              q_data,
	output logic                   q_rd,
	output logic                   ov_q,
	input  logic                   ordy,
	output logic [7:0]             byte_q,
	output logic [OFFSET_BITS-1:0] boff_q,
	output logic                   last_q,
	output logic                   ovf_q
);

	logic [CAP_BITS-1:0] cap_q, off_q;
	xie_desc_t cur_q;
	logic      cur_v_q;
	logic [3:0] k_q, n, p;
	logic [7:0] b;
	logic       adv, stored;

	assign n = 4'(cur_q.np) + 4'(cur_q.mr_en) + 4'(cur_q.sib) + 4'(cur_q.dl) + 4'(cur_q.il);
	assign adv = cur_v_q && (!ov_q || ordy);
	assign q_rd = !cur_v_q && !q_empty;
	assign stored = (off_q < cap_q) && (off_q < CAP_BITS'(1 << OFFSET_BITS));

	// walk the regions: prefix/opcode, ModRM, SIB, disp, imm
	always_comb begin
		p = k_q;
		b = 8'h00;
		if (p < 4'(cur_q.np)) begin
			b = cur_q.pre[p[1:0]];
		end else begin
			p = p - 4'(cur_q.np);
			if (cur_q.mr_en && p == 4'd0) begin
				b = cur_q.mr;
			end else begin
				p = p - 4'(cur_q.mr_en);
				if (cur_q.sib && p == 4'd0) begin
					b = 8'h24;
				end else begin
					p = p - 4'(cur_q.sib);
					if (p < 4'(cur_q.dl)) begin
						b = cur_q.disp[p[1:0]*8 +: 8];
					end else begin
						p = p - 4'(cur_q.dl);
						b = cur_q.imm[p[1:0]*8 +: 8];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) cur_q <= q_data;
		if (adv) begin
			byte_q <= b;
			boff_q <= stored ? off_q[OFFSET_BITS-1:0] : '0;
			last_q <= (k_q == n - 4'd1);
			ovf_q  <= !stored;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_BITS'(1 << OFFSET_BITS);
			off_q   <= '0;
			cur_v_q <= 1'b0;
			k_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (q_rd) begin
				if (q_data.rewind) begin
					off_q <= '0;
				end else begin
					cur_v_q <= 1'b1;
					k_q     <= '0;
				end
			end
			if (adv) begin
				ov_q <= 1'b1;
				if (stored) off_q <= off_q + 1'b1;
				if (k_q == n - 4'd1) cur_v_q <= 1'b0;
				else k_q <= k_q + 4'd1;
			end else if (ordy) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/x86_64_instruction_byte_encoder.sv =====
// Top level of the x86-64 instruction byte encoder.
// Path of an item: queue, current-descriptor register, then the byte output register.
// Output: one byte per cycle within an instruction while m_tready is high, and a
// descriptor pop between instructions; the byte walker sets the rate.
// Reset (arst_n low, async): queue empty, offset 0, capacity 65536, no output valid.
`timescale 1ns / 1ps
module x86_64_instruction_byte_encoder import xie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[6:0], reg_a[10:7], reg_b[14:11], cond_code[18:15],
	// displacement[50:19], immediate[82:51], zero pad
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// code_byte[7:0], byte_offset[23:8]
	output logic [OFFSET_BITS+7:0] m_tdata,
	output logic        m_tlast,
	// overflow[0]
	output logic        m_tuser,
	input  logic        cfg_we,
	input  logic [CAP_BITS-1:0] cfg_wdata
);

	logic      push, full, empty, q_rd;
	xie_desc_t fdesc, qdesc;
	logic [7:0] byte_q;
	logic [OFFSET_BITS-1:0] boff_q;

	// front decodes in the accepting cycle; items that emit nothing, except rewinds, are dropped
	xie_front u_front (
		.opcode      (s_tdata[6:0]),
		.reg_a       (s_tdata[10:7]),
		.reg_b       (s_tdata[14:11]),
		.cond_code   (s_tdata[18:15]),
		.displacement(s_tdata[50:19]),
		.immediate   (s_tdata[82:51]),
		.push        (push),
		.desc        (fdesc)
	);

	assign s_tready = !full;

	xie_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (s_tvalid && push),
		.wdata (fdesc),
		.full  (full),
		.rd    (q_rd),
		.empty (empty),
		.rdata (qdesc)
	);

	// back walks bytes into an output register; rewinds act in queue order
	xie_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_empty  (empty),
		.q_data   (qdesc),
		.q_rd     (q_rd),
		.ov_q     (m_tvalid),
		.ordy     (m_tready),
		.byte_q   (byte_q),
		.boff_q   (boff_q),
		.last_q   (m_tlast),
		.ovf_q    (m_tuser)
	);

	assign m_tdata = {boff_q, byte_q};

endmodule

// ===== design/xie_checker.sv =====
// Port-level checks for the encoder, bound to the top level.
`timescale 1ns / 1ps
module xie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	a_ovf_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[23:8] == 16'd0)
		else $error("dropped byte has nonzero offset");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside an instruction");

endmodule

bind x86_64_instruction_byte_encoder xie_checker u_xie_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

// ===== tb/x86_64_instruction_byte_encoder_tb.sv =====
// Testbench for the x86-64 instruction byte encoder: directed and random stream traffic against a byte predictor.
`timescale 1ns / 1ps
module x86_64_instruction_byte_encoder_tb;
	import xie_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int MAX_MISMATCH_PRINT = 10;
	localparam logic [6:0] F_LAST_FORM = 7'd70;
	localparam logic [6:0] F_REWIND = 7'd71;

	typedef struct {
		logic [7:0]  code;
		logic [15:0] offs;
		logic        last;
		logic        ovf;
	} enc_byte_t;

	// Encoder model: holds capacity and offset, predicts bytes per request.
	class encoder_scoreboard;
		enc_byte_t pending[$];
		int unsigned errors;
		logic [16:0] capacity;
		logic [16:0] offset;
		logic [7:0]  bytes[$];

		function new();
			errors = 0;
			capacity = 17'd65536;
			offset = 0;
		endfunction

		function bit is8(logic [31:0] v);
			return (v <= 32'h7f) || (v >= 32'hffffff80);
		endfunction

		function void b1(logic [31:0] v);
			bytes.push_back(v[7:0]);
		endfunction

		function void b4(logic [31:0] v);
			b1(v); b1(v >> 8); b1(v >> 16); b1(v >> 24);
		endfunction

		function void rexb(logic [3:0] r, logic [3:0] b);
			b1(32'h48 | (r[3] ? 4 : 0) | (b[3] ? 1 : 0));
		endfunction

		function void modrm(logic [1:0] md, logic [3:0] rg, logic [3:0] rm);
			b1({md, rg[2:0], rm[2:0]});
			if (md != 2'd3 && rm[2:0] == 3'd4)
				b1(32'h24);
		endfunction

		function void mem(logic [3:0] rg, logic [3:0] base, logic [31:0] d);
			if (is8(d)) begin
				modrm(2'd1, rg, base); b1(d);
			end else begin
				modrm(2'd2, rg, base); b4(d);
			end
		endfunction

		function void alu32(logic [3:0] a, logic [31:0] i, logic [3:0] ext, logic [7:0] eax_op);
			if (a == 0) begin
				b1(eax_op); b4(i);
			end else begin
				b1(32'h81); modrm(2'd3, ext, a); b4(i);
			end
		endfunction

		function void addsub(logic [3:0] a, logic [31:0] i, logic [3:0] ext, logic [7:0] eax_op);
			if (is8(i)) begin
				b1(32'h83); modrm(2'd3, ext, a); b1(i);
			end else
				alu32(a, i, ext, eax_op);
		endfunction

		function void shifter(logic [3:0] a, logic [31:0] i, logic [3:0] ext);
			if (i[7:0] == 0)
				return;
			if (i[7:0] == 1) begin
				b1(32'hd1); modrm(2'd3, ext, a);
			end else begin
				b1(32'hc1); modrm(2'd3, ext, a); b1(i[7:0]);
			end
		endfunction

		// Note one accepted request and queue its predicted bytes.
		function void note_request(logic [6:0] op, logic [3:0] a, logic [3:0] b,
				logic [3:0] cc, logic [31:0] d, logic [31:0] i);
			logic [7:0] sse[9];
			logic [3:0] gext[5];
			logic [16:0] lim;
			enc_byte_t e;
			sse = '{8'h10, 8'h11, 8'h58, 8'h5c, 8'h59, 8'h5e, 8'h51, 8'h2c, 8'h2a};
			gext = '{4'd0, 4'd5, 4'd4, 4'd1, 4'd6};
			bytes.delete();
			if (op == F_REWIND) begin
				offset = 0;
				return;
			end
			case (op)
				0: begin rexb(b, a); b1(32'h89); modrm(3, b, a); end
				1: begin b1(32'h89); modrm(3, b, a); end
				2: begin b1(32'hb8 | a[2:0]); b4(i); end
				3: begin rexb(0, a); b1(32'hc7); modrm(3, 0, a); b4(i); end
				4: begin rexb(b, a); b1(32'h89); mem(b, a, d); end
				5: begin b1(32'hc7); mem(0, a, d); b4(i); end
				6: begin rexb(b, a); b1(32'h8b); mem(b, a, d); end
				7: b1(32'hc3);
				8: begin b1(32'h8b); mem(b, a, d); end
				9: begin b1(32'h89); mem(b, a, d); end
				10: begin b1(32'h0f); b1(32'hbe); modrm(3, a, b); end
				11: begin b1(32'h0f); b1(32'hbf); modrm(3, a, b); end
				12: begin rexb(a, 0); b1(32'h63); modrm(3, a, b); end
				13: begin rexb(b, a); b1(32'h63); mem(b, a, d); end
				14: begin b1(32'h0f); b1(32'hb6); modrm(3, a, b); end
				15: begin b1(32'h0f); b1(32'hb7); modrm(3, a, b); end
				16: if (i != 0) begin rexb(0, a); addsub(a, i, 0, 8'h05); end
				17: if (i != 0) addsub(a, i, 0, 8'h05);
				18: begin b1(32'h01); modrm(3, b, a); end
				19: if (i[7:0] != 8'hff) begin
					if (a == 0) b1(32'h24);
					else begin b1(32'h80); modrm(3, 4, a); end
					b1(i);
				end
				20: if (i != 32'hffffffff) alu32(a, i, 4, 8'h25);
				21: begin b1(32'h21); modrm(3, b, a); end
				22: if (i != 0) begin rexb(0, a); addsub(a, i, 5, 8'h2d); end
				23: if (i != 0) addsub(a, i, 5, 8'h2d);
				24: begin b1(32'h29); modrm(3, b, a); end
				25: shifter(a, i, 4);
				26: begin b1(32'hd3); modrm(3, 4, a); end
				27: shifter(a, i, 7);
				28: begin b1(32'hd3); modrm(3, 7, a); end
				29: shifter(a, i, 5);
				30: begin b1(32'hd3); modrm(3, 5, a); end
				31: if (i != 0) alu32(a, i, 6, 8'h35);
				32: begin b1(32'h31); modrm(3, b, a); end
				33: begin rexb(b, a); b1(32'h31); modrm(3, b, a); end
				34: if (i != 0) alu32(a, i, 1, 8'h0d);
				35: begin b1(32'h09); modrm(3, b, a); end
				36: begin rexb(b, a); b1(32'h39); modrm(3, b, a); end
				37: begin b1(32'h39); modrm(3, b, a); end
				38: alu32(a, i, 7, 8'h3d);
				39: begin b1(32'hff); mem(2, a, d); end
				40: begin b1(32'hf7); modrm(3, 4, a); end
				41: begin b1(32'hf7); modrm(3, 5, a); end
				42: b1(32'h50 | a[2:0]);
				43: b1(32'h58 | a[2:0]);
				44: b1(32'h90);
				45: begin b1(32'h0f); b1(32'h90 | cc); modrm(3, 0, a); end
				46: begin b1(32'h0f); b1(32'h40 | cc); modrm(3, a, b); end
				47, 48, 49, 50, 51, 52, 53, 54, 55: begin
					b1(32'hf3); b1(32'h0f); b1(sse[op - 47]);
					modrm(2, b, a); b4(d);
				end
				56: begin b1(32'h66); b1(32'h0f); b1(32'h7e); modrm(3, b, a); end
				57: begin b1(32'h66); b1(32'h0f); b1(32'h6e); modrm(3, b, a); end
				58, 59, 60, 61, 62: begin
					b1(is8(i) ? 32'h83 : 32'h81);
					mem(gext[op - 58], a, d);
					if (is8(i)) b1(i); else b4(i);
				end
				63: begin b1(32'hc1); mem(4, a, d); b1(i); end
				64: begin b1(32'hc1); mem(5, a, d); b1(i); end
				65: begin b1(32'hc1); mem(7, a, d); b1(i); end
				66: begin b1(32'h3b); mem(b, a, d); end
				67: begin b1(32'h39); mem(b, a, d); end
				68: begin b1(32'h01); mem(b, a, d); end
				69: begin b1(32'hf7); mem(4, a, d); end
				70: begin b1(32'hf7); mem(5, a, d); end
				default: ;
			endcase
			lim = (capacity < 17'd65536) ? capacity : 17'd65536;
			for (int k = 0; k < bytes.size(); k++) begin
				e.code = bytes[k];
				e.last = (k == bytes.size() - 1);
				e.ovf = !(offset < lim);
				e.offs = e.ovf ? 16'd0 : offset[15:0];
				if (!e.ovf)
					offset = offset + 1;
				pending.push_back(e);
			end
		endfunction

		// Compare one accepted output byte with the oldest prediction.
		function void check_byte(logic [7:0] code, logic [15:0] offs, logic last, logic ovf);
			enc_byte_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_MISMATCH_PRINT)
					$display("unexpected byte %h offs %0d", code, offs);
				return;
			end
			e = pending.pop_front();
			if (e.code !== code || e.offs !== offs || e.last !== last || e.ovf !== ovf) begin
				errors++;
				if (errors <= MAX_MISMATCH_PRINT)
					$display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
						e.code, e.offs, e.last, e.ovf, code, offs, last, ovf);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [87:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OFFSET_BITS+7:0] m_tdata;
	logic m_tlast;
	logic m_tuser;
	logic cfg_we = 0;
	logic [CAP_BITS-1:0] cfg_wdata = '0;

	encoder_scoreboard sb;
	bit quiet_tail = 0;   // no idling near the end
	int unsigned stuck_cycles = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	x86_64_instruction_byte_encoder DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Sink: checks each accepted byte; random stall bursts on the ready.
	initial begin : sink
		int stall;
		sb = new();
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_byte(m_tdata[7:0], m_tdata[OFFSET_BITS+7:8], m_tlast, m_tuser);
			if (stall > 0)
				stall--;
			else if (!quiet_tail && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 17);
			m_tready <= (stall == 0) && arst_n;
		end
	end

	// Watchdog: cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Send one request; the model sees it at the accepting edge.
	task automatic send(logic [6:0] op, logic [3:0] a, logic [3:0] b, logic [3:0] cc,
			logic [31:0] d, logic [31:0] i);
		s_tdata <= {5'd0, i, d, cc, b, a, op};
		s_tvalid <= 1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(op, a, b, cc, d, i);
	endtask

	task automatic gap();
		int n;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			n = $urandom_range(1, 17);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_capacity(logic [16:0] c);
		cfg_wdata <= c;
		cfg_we <= 1;
		@(posedge clk);
		cfg_we <= 0;
		sb.capacity = c;
	endtask

	function automatic logic [31:0] rnd_value();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 127);
			1: return -$urandom_range(1, 128);
			2: return $urandom_range(0, 2);
			3: return 32'h7fffffff;
			4: return 32'h80000000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_burst(int n);
		logic [6:0] op;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 40) == 0)
				op = (k & 1) ? F_REWIND : 7'($urandom_range(72, 127));
			else
				op = 7'($urandom_range(0, F_LAST_FORM));
			send(op, 4'($urandom), 4'($urandom), 4'($urandom), rnd_value(), rnd_value());
			gap();
		end
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: short forms, SIB base, disp8/disp32 limits, identity ops.
		send(7'd0, 4'd15, 4'd8, 4'd0, 0, 0);
		send(7'd4, 4'd4, 4'd12, 4'd0, 32'd127, 0);
		send(7'd6, 4'd12, 4'd3, 4'd0, 32'd128, 0);
		send(7'd8, 4'd5, 4'd0, 4'd0, 32'hffffff80, 0);
		send(7'd9, 4'd1, 4'd2, 4'd0, 32'hffffff7f, 0);
		send(7'd17, 4'd0, 4'd0, 4'd0, 0, 32'h1000);           // eax short form
		send(7'd17, 4'd3, 4'd0, 4'd0, 0, 0);                  // add 0: nothing
		send(7'd20, 4'd0, 4'd0, 4'd0, 0, 32'hffffffff);       // and all-ones: nothing
		send(7'd19, 4'd0, 4'd0, 4'd0, 0, 32'h0f);
		send(7'd19, 4'd9, 4'd0, 4'd0, 0, 32'hff);
		send(7'd25, 4'd2, 4'd0, 4'd0, 0, 32'h100);            // shift by 0
		send(7'd27, 4'd2, 4'd0, 4'd0, 0, 32'd1);
		send(7'd29, 4'd7, 4'd0, 4'd0, 0, 32'd5);
		send(7'd45, 4'd1, 4'd0, 4'd15, 0, 0);
		send(7'd46, 4'd10, 4'd11, 4'd0, 0, 0);
		send(7'd47, 4'd4, 4'd15, 4'd0, 32'h80000000, 0);
		send(7'd58, 4'd12, 4'd0, 4'd0, 32'h7fffffff, 32'h80000000); // longest form
		send(7'd62, 4'd4, 4'd0, 4'd0, 32'd1, 32'h7f);
		send(7'd38, 4'd0, 4'd0, 4'd0, 0, 0);
		send(7'd127, 4'd0, 4'd0, 4'd0, 0, 0);                 // ignored form
		send(F_REWIND, 4'd0, 4'd0, 4'd0, 0, 0);
		for (int f = 0; f <= F_LAST_FORM; f++) begin
			send(7'(f), 4'($urandom), 4'($urandom), 4'($urandom), $urandom, $urandom);
			gap();
		end
		drain();   // sender holds until every byte is back

		// Capacity extremes, with overflow and rewind.
		set_capacity(17'd1);
		random_burst(40);
		drain();
		set_capacity(17'd0);
		random_burst(20);
		drain();
		set_capacity(17'd65535);
		random_burst(60);
		drain();
		set_capacity(17'($urandom_range(5, 60)));
		send(F_REWIND, 4'd0, 4'd0, 4'd0, 0, 0);
		random_burst(60);
		drain();
		set_capacity(17'd65536);
		send(F_REWIND, 4'd0, 4'd0, 4'd0, 0, 0);
		random_burst(54);
		quiet_tail = 1;
		random_burst(60);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
design/xie_pkg.sv
design/xie_front.sv
design/xie_queue.sv
design/xie_back.sv
design/x86_64_instruction_byte_encoder.sv
design/xie_checker.sv
tb/x86_64_instruction_byte_encoder_tb.sv
